FILE: hdl/keyed_base64_cipher_defines.svh
// Assertion macros shared by the keyed Base64 cipher RTL.
`ifndef KEYED_BASE64_CIPHER_DEFINES_SVH
`define KEYED_BASE64_CIPHER_DEFINES_SVH

// Implication checked on every clock edge while out of reset.
`define KBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("label failed");

// Next-cycle implication checked while out of reset.
`define KBC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("label failed");

`endif

FILE: hdl/kb64c_pkg.sv
// Package: constants, state codes and tables for the keyed Base64 cipher.
`timescale 1ns / 1ps
`default_nettype none
package kb64c_pkg;

  localparam int KEY_MAX_DEF = 32;
  localparam int ENC_BLOCK   = 12;
  localparam int DEC_BLOCK   = 16;
  localparam logic [7:0] PAD_CHAR = 8'd61;
  localparam logic [7:0] BAD_CODE = 8'd255;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_KLEN = 3'd1;
  localparam logic [2:0] CFG_KW0  = 3'd2;
  localparam logic [2:0] CFG_KW1  = 3'd3;
  localparam logic [2:0] CFG_KW2  = 3'd4;
  localparam logic [2:0] CFG_KW3  = 3'd5;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_INIT  = 10'b0000000010,
    ST_PERMA = 10'b0000000100,
    ST_PERMB = 10'b0000001000,
    ST_INV   = 10'b0000010000,
    ST_WORK  = 10'b0000100000,
    ST_LOOK  = 10'b0001000000,
    ST_EMIT  = 10'b0010000000,
    ST_REKA  = 10'b0100000000,
    ST_REKB  = 10'b1000000000
  } state_t;

  function automatic logic [7:0] std_alpha(input logic [5:0] i);
    logic [7:0] r;
    begin
      if (i < 6'd26) r = 8'd65 + {2'b00, i};
      else if (i < 6'd52) r = 8'd71 + {2'b00, i};
      else if (i < 6'd62) r = {2'b00, i} - 8'd4;
      else if (i == 6'd62) r = 8'd43;
      else r = 8'd47;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/keyed_base64_cipher.sv
// Top level: keyed Base64 cipher with alphabet, inverse table and key in memories.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_base64_cipher_defines.svh"
// Keyed Base64 cipher. Encrypt (mode 0) turns bytes into characters, four per
// triple. Decrypt (mode 1) turns four characters into up to three bytes. After
// reset the block loads the standard alphabet and inverse table and clears the
// key, with in_stall high. An item with first set repeats that sweep and also
// loads the key from the configuration words. At each block start the alphabet
// is permuted by 64 swaps on the alphabet memory. In decrypt the inverse table
// is then rebuilt. An item is then packed into the group, looked up in the
// tables when a group completes, and its results are delivered one per cycle
// while out_stall is low. At block end the key is rewritten through the
// alphabet. One item is taken at a time; in_stall is high while it is worked on.
module keyed_base64_cipher #(
  parameter int KEY_MAX = kb64c_pkg::KEY_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_first,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_end_of_run,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int LW = $clog2(KEY_MAX + 1);

  // configuration registers
  logic        mode_r;
  logic [5:0]  klen_r;
  logic [63:0] kw_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      klen_r <= 6'd1;
      for (int i = 0; i < 4; i++) kw_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        kb64c_pkg::CFG_MODE: mode_r <= cfg_data[0];
        kb64c_pkg::CFG_KLEN: klen_r <= cfg_data[5:0];
        kb64c_pkg::CFG_KW0:  kw_r[0] <= cfg_data;
        kb64c_pkg::CFG_KW1:  kw_r[1] <= cfg_data;
        kb64c_pkg::CFG_KW2:  kw_r[2] <= cfg_data;
        kb64c_pkg::CFG_KW3:  kw_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective key length, clamped to 1..KEY_MAX
  logic [LW-1:0] elen;
  always_comb begin
    if (klen_r == 6'd0) elen = LW'(1);
    else if (32'(klen_r) > KEY_MAX) elen = LW'(KEY_MAX);
    else elen = LW'(klen_r);
  end

  // memories: alphabet (64), inverse table (128), working key (KEY_MAX)
  logic [7:0] alpha_mem [64];
  logic [7:0] inv_mem   [128];
  logic [7:0] key_mem   [KEY_MAX];
  logic       a_we, i_we, k_we;
  logic [5:0] a_wa, a_ra;
  logic [6:0] i_wa, i_ra;
  logic [KW-1:0] k_wa, k_ra;
  logic [7:0] a_wd, i_wd, k_wd;
  logic [7:0] a_rd, i_rd, k_rd;

  always_ff @(posedge clk) begin
    if (a_we) alpha_mem[a_wa] <= a_wd;
    a_rd <= alpha_mem[a_ra];
  end
  always_ff @(posedge clk) begin
    if (i_we) inv_mem[i_wa] <= i_wd;
    i_rd <= inv_mem[i_ra];
  end
  always_ff @(posedge clk) begin
    if (k_we) key_mem[k_wa] <= k_wd;
    k_rd <= key_mem[k_ra];
  end

  // control
  kb64c_pkg::state_t st_r, st_nxt;
  logic [6:0]  cnt_r, cnt_nxt;       // sweep index
  logic [1:0]  sub_r, sub_nxt;       // step within a swap, inverse rebuild or rekey
  logic [7:0]  tmp_r, tmp_nxt;       // held alphabet entry i
  logic [5:0]  idx_r, idx_nxt;       // swap partner
  logic [KW-1:0] kp_r, kp_nxt;       // key position i mod len
  logic [7:0]  c_r;
  logic        last_r, dec_r;
  logic [23:0] gbuf_r, gbuf_nxt;
  logic [1:0]  gcnt_r, gcnt_nxt;
  logic [3:0]  bcnt_r, bcnt_nxt;
  logic [7:0]  res_r [4];
  logic [7:0]  res_nxt [4];
  logic [2:0]  nres_r, nres_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic [7:0]  dv_r [4];             // decoded characters, 255 when outside the alphabet
  logic [7:0]  dv_nxt [4];
  logic [7:0]  ch_r [4];
  logic [7:0]  ch_nxt [4];
  logic        boot_done_r, boot_done_nxt; // reset-time table load finished
  logic        take;

  assign take = in_valid && !in_stall;
  assign in_stall = (st_r != kb64c_pkg::ST_IDLE);
  assign out_valid = (st_r == kb64c_pkg::ST_EMIT) && (nres_r != 3'd0);
  assign out_byte = res_r[oidx_r[1:0]];
  assign out_end_of_run = (oidx_r + 3'd1 == nres_r);

  // key byte from configuration words
  function automatic logic [7:0] cfg_key(input int i, input logic [63:0] w0,
      input logic [63:0] w1, input logic [63:0] w2, input logic [63:0] w3);
    logic [63:0] w;
    begin
      case (i / 8)
        0: w = w0;
        1: w = w1;
        2: w = w2;
        3: w = w3;
        default: w = '0;
      endcase
      return (i < 32) ? w[(i % 8) * 8 +: 8] : 8'd0;
    end
  endfunction

  logic [7:0] init_key;
  always_comb begin
    init_key = '0;
    for (int i = 0; i < KEY_MAX; i++)
      if (cnt_r[KW-1:0] == KW'(i)) init_key = cfg_key(i, kw_r[0], kw_r[1], kw_r[2], kw_r[3]);
  end

  logic [23:0] enc_t;
  logic [1:0]  bsel;
  always_comb begin
    bsel = gcnt_r;
    enc_t = gbuf_r;
    case (bsel)
      2'd0: enc_t[7:0]   = gbuf_r[7:0] | c_r;
      2'd1: enc_t[15:8]  = gbuf_r[15:8] | c_r;
      2'd2: enc_t[23:16] = gbuf_r[23:16] | c_r;
      default: enc_t = gbuf_r;     // a fourth byte falls beyond 24 bits: drop it
    endcase
  end

  logic [4:0] bc_inc;
  logic       blk_end;
  assign bc_inc = {1'b0, bcnt_r} + 5'd1;
  assign blk_end = last_r || (!dec_r && bc_inc >= 5'(kb64c_pkg::ENC_BLOCK)) ||
                   (dec_r && bc_inc >= 5'(kb64c_pkg::DEC_BLOCK));

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; sub_nxt = sub_r; tmp_nxt = tmp_r; idx_nxt = idx_r;
    kp_nxt = kp_r; gbuf_nxt = gbuf_r; gcnt_nxt = gcnt_r; bcnt_nxt = bcnt_r;
    nres_nxt = nres_r; oidx_nxt = oidx_r; boot_done_nxt = boot_done_r;
    for (int k = 0; k < 4; k++) begin
      res_nxt[k] = res_r[k]; dv_nxt[k] = dv_r[k]; ch_nxt[k] = ch_r[k];
    end
    a_we = 1'b0; i_we = 1'b0; k_we = 1'b0;
    a_wa = '0; i_wa = '0; k_wa = '0; a_wd = '0; i_wd = '0; k_wd = '0;
    a_ra = cnt_r[5:0]; i_ra = '0; k_ra = kp_r;
    case (st_r)
      kb64c_pkg::ST_IDLE: begin
        if (take) begin
          cnt_nxt = '0; sub_nxt = '0; kp_nxt = '0;
          if (in_first) begin
            st_nxt = kb64c_pkg::ST_INIT;
            gbuf_nxt = '0; gcnt_nxt = '0; bcnt_nxt = '0;
          end else if (bcnt_r == 4'd0) begin
            st_nxt = kb64c_pkg::ST_PERMA;
          end else begin
            st_nxt = kb64c_pkg::ST_WORK;
          end
        end
      end
      // reload alphabet, inverse table and key, one entry of each per cycle;
      // the load after reset clears the key and returns to idle
      kb64c_pkg::ST_INIT: begin
        i_we = 1'b1; i_wa = cnt_r;
        i_wd = kb64c_pkg::BAD_CODE;
        for (int j = 0; j < 64; j++)
          if (kb64c_pkg::std_alpha(6'(j)) == {1'b0, cnt_r}) i_wd = 8'(j);
        if (cnt_r < 7'd64) begin
          a_we = 1'b1; a_wa = cnt_r[5:0]; a_wd = kb64c_pkg::std_alpha(cnt_r[5:0]);
        end
        if (32'(cnt_r) < KEY_MAX) begin
          k_we = 1'b1; k_wa = cnt_r[KW-1:0]; k_wd = boot_done_r ? init_key : 8'd0;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          cnt_nxt = '0;
          st_nxt = boot_done_r ? kb64c_pkg::ST_PERMA : kb64c_pkg::ST_IDLE;
          boot_done_nxt = 1'b1;
        end
      end
      // swap: sub 0 read a[i] and key; sub 1 read a[idx]; sub 2 hold a[idx]
      kb64c_pkg::ST_PERMA: begin
        a_ra = cnt_r[5:0]; k_ra = kp_r;
        case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: begin
            tmp_nxt = a_rd; idx_nxt = k_rd[5:0];
            a_ra = k_rd[5:0];
            sub_nxt = 2'd2;
          end
          default: begin
            a_ra = idx_r;
            st_nxt = kb64c_pkg::ST_PERMB;
          end
        endcase
      end
      kb64c_pkg::ST_PERMB: begin
        // a_rd = a[idx]; write a[i]=a[idx] then a[idx]=tmp
        if (sub_r == 2'd2) begin
          a_we = 1'b1; a_wa = cnt_r[5:0]; a_wd = a_rd; sub_nxt = 2'd3;
        end else begin
          a_we = 1'b1; a_wa = idx_r; a_wd = tmp_r; sub_nxt = 2'd0;
          kp_nxt = (32'(kp_r) + 1 >= 32'(elen)) ? '0 : kp_r + KW'(1);
          cnt_nxt = cnt_r + 7'd1;
          st_nxt = kb64c_pkg::ST_PERMA;
          if (cnt_r == 7'd63) begin
            cnt_nxt = '0;
            st_nxt = mode_r ? kb64c_pkg::ST_INV : kb64c_pkg::ST_WORK;
          end
        end
      end
      // inverse rebuild: read a[i], write inv next cycle
      kb64c_pkg::ST_INV: begin
        a_ra = cnt_r[5:0];
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          i_we = 1'b1; i_wa = a_rd[6:0]; i_wd = {2'b00, cnt_r[5:0]};
          sub_nxt = 2'd0; cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            cnt_nxt = '0; st_nxt = kb64c_pkg::ST_WORK;
          end
        end
      end
      // pack the item into the group, decide whether a group completes
      kb64c_pkg::ST_WORK: begin
        cnt_nxt = '0; sub_nxt = '0;
        if (!dec_r) begin
          if (gcnt_r >= 2'd2 || last_r) begin
            gbuf_nxt = enc_t;
            nres_nxt = 3'd4;
            st_nxt = kb64c_pkg::ST_LOOK;
          end else begin
            gbuf_nxt = enc_t; gcnt_nxt = gcnt_r + 2'd1; nres_nxt = 3'd0;
            st_nxt = kb64c_pkg::ST_EMIT;
          end
        end else begin
          if (gcnt_r == 2'd3 || last_r) begin
            for (int k = 0; k < 4; k++) begin
              if (k < int'(gcnt_r)) ch_nxt[k] = gbuf_r[8*k +: 8];
              else if (k == int'(gcnt_r)) ch_nxt[k] = c_r;
              else ch_nxt[k] = kb64c_pkg::PAD_CHAR;
            end
            nres_nxt = 3'd3;
            st_nxt = kb64c_pkg::ST_LOOK;
          end else begin
            gbuf_nxt[8*gcnt_r +: 8] = c_r;
            gcnt_nxt = gcnt_r + 2'd1; nres_nxt = 3'd0;
            st_nxt = kb64c_pkg::ST_EMIT;
          end
        end
        oidx_nxt = '0;
      end
      // four table reads, one per cycle, each answered from a registered memory output
      kb64c_pkg::ST_LOOK: begin
        a_ra = gbuf_r[6*cnt_r[1:0] +: 6];
        i_ra = ch_r[cnt_r[1:0]][6:0];
        if (cnt_r != 7'd0) begin
          if (!dec_r) res_nxt[cnt_r[1:0] - 2'd1] = a_rd;
          else dv_nxt[cnt_r[1:0] - 2'd1] =
                 ch_r[cnt_r[1:0] - 2'd1][7] ? kb64c_pkg::BAD_CODE : i_rd;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd4) begin
          cnt_nxt = '0;
          if (!dec_r) begin
            res_nxt[3] = a_rd;
            if (last_r && gcnt_r == 2'd0) begin
              res_nxt[2] = kb64c_pkg::PAD_CHAR; res_nxt[3] = kb64c_pkg::PAD_CHAR;
            end else if (last_r && gcnt_r == 2'd1) begin
              res_nxt[3] = kb64c_pkg::PAD_CHAR;
            end
          end else begin
            logic [7:0] d0, d1, d2, d3;
            d0 = dv_r[0];
            d1 = dv_r[1];
            d2 = dv_r[2];
            d3 = (ch_r[3][7]) ? kb64c_pkg::BAD_CODE : i_rd;
            res_nxt[0] = 8'(d0 | (d1 << 6));
            res_nxt[1] = 8'((d1 >> 2) | (d2 << 4));
            res_nxt[2] = 8'((d2 >> 4) | (d3 << 2));
            if (last_r && ch_r[2] == kb64c_pkg::PAD_CHAR) nres_nxt = 3'd1;
            else if (last_r && ch_r[3] == kb64c_pkg::PAD_CHAR) nres_nxt = 3'd2;
          end
          gbuf_nxt = '0; gcnt_nxt = '0;
          st_nxt = kb64c_pkg::ST_EMIT;
        end
      end
      // deliver results, then advance the block
      kb64c_pkg::ST_EMIT: begin
        if (nres_r == 3'd0 || (!out_stall && oidx_r + 3'd1 == nres_r)) begin
          bcnt_nxt = blk_end ? 4'd0 : bc_inc[3:0];
          if (last_r) begin
            gbuf_nxt = '0; gcnt_nxt = '0;
          end
          cnt_nxt = '0; sub_nxt = '0;
          st_nxt = blk_end ? kb64c_pkg::ST_REKA : kb64c_pkg::ST_IDLE;
        end else if (!out_stall) begin
          oidx_nxt = oidx_r + 3'd1;
        end
      end
      // rekey: read key[j], then alphabet[key], then write key[j]
      kb64c_pkg::ST_REKA: begin
        k_ra = cnt_r[KW-1:0];
        if (sub_r == 2'd0) sub_nxt = 2'd1;
        else begin
          a_ra = k_rd[5:0]; sub_nxt = 2'd0; st_nxt = kb64c_pkg::ST_REKB;
        end
      end
      kb64c_pkg::ST_REKB: begin
        k_we = 1'b1; k_wa = cnt_r[KW-1:0]; k_wd = a_rd;
        cnt_nxt = cnt_r + 7'd1;
        st_nxt = kb64c_pkg::ST_REKA;
        if (32'(cnt_r) + 1 >= 32'(elen)) begin
          cnt_nxt = '0; st_nxt = kb64c_pkg::ST_IDLE;
        end
      end
      default: st_nxt = kb64c_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kb64c_pkg::ST_INIT;
      cnt_r <= '0; sub_r <= '0; kp_r <= '0;
      gbuf_r <= '0; gcnt_r <= '0; bcnt_r <= '0;
      nres_r <= '0; oidx_r <= '0; boot_done_r <= 1'b0;
      last_r <= 1'b0; dec_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt; sub_r <= sub_nxt; kp_r <= kp_nxt;
      gbuf_r <= gbuf_nxt; gcnt_r <= gcnt_nxt; bcnt_r <= bcnt_nxt;
      nres_r <= nres_nxt; oidx_r <= oidx_nxt; boot_done_r <= boot_done_nxt;
      if (take) begin
        last_r <= in_last; dec_r <= mode_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    tmp_r <= tmp_nxt; idx_r <= idx_nxt;
    if (take) c_r <= in_byte;
    for (int k = 0; k < 4; k++) begin
      res_r[k] <= res_nxt[k]; dv_r[k] <= dv_nxt[k]; ch_r[k] <= ch_nxt[k];
    end
  end

  `KBC_ASSERT_IMP(a_stall_busy, out_valid, in_stall)
  `KBC_ASSERT_IMP(a_oidx_range, out_valid && nres_r != 3'd0, oidx_r < nres_r)
  `KBC_ASSERT_NXT(a_take_leaves_idle, take, st_r != kb64c_pkg::ST_IDLE)
  `KBC_ASSERT_IMP(a_one_hot, 1'b1, $onehot(st_r))
endmodule
`default_nettype wire
